// File: rtl/spd_pkg.sv
// Shared types and constants of the segment pair distance block.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package spd_pkg;

    localparam int COORD_BITS = 12;
    localparam int DLT_W = COORD_BITS + 1;
    localparam int PRD_W = 2 * DLT_W;
    localparam int SUM_W = PRD_W + 1;
    localparam int SQ_W = 2 * COORD_BITS + 1;
    localparam int DIST_BITS = 17;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef struct packed {
        logic [COORD_BITS-1:0] seg1_start_x;
        logic [COORD_BITS-1:0] seg1_start_y;
        logic [COORD_BITS-1:0] seg1_end_x;
        logic [COORD_BITS-1:0] seg1_end_y;
        logic [COORD_BITS-1:0] seg2_start_x;
        logic [COORD_BITS-1:0] seg2_start_y;
        logic [COORD_BITS-1:0] seg2_end_x;
        logic [COORD_BITS-1:0] seg2_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic                 crossing;
        logic [DIST_BITS-1:0] nearest_distance;
        logic [DIST_BITS-1:0] farthest_distance;
    } t_seg_dist;

endpackage

`default_nettype wire

// File: rtl/segment_pair_distance.sv
// Top level of the segment pair distance block: crossing test, four distance lanes,
// dividers, square roots and the min/max merge. Depends on spd_pkg, spd_cross, spd_lane, spd_div and spd_sqrt.
// The block takes a segment pair word in every cycle and never raises busy. Each result
// word passes the lane front end, the divider pipeline, the square root pipeline and the
// merge registers, where QW = 2*COORD_BITS + 1 + 2*FRAC_BITS is the length of the
// divider pipeline and SW = (QW + 1) / 2 the length of the square root pipeline.
// Results leave in input order with no gaps, so the receiver must take a word in every
// cycle that o_valid is high.
`default_nettype none

module segment_pair_distance #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire spd_pkg::t_seg_pair i_item,
    output logic                    o_valid,
    output spd_pkg::t_seg_dist      o_result
);
    import spd_pkg::*;

    localparam int QW = SQ_W + 2 * FRAC_BITS;
    localparam int SW = (QW + 1) / 2;
    localparam int NW = SQ_W + QW;
    localparam int LAT = 5 + QW + SW + 2;
    localparam int XD = 1 + QW + SW;

    logic                  w_acc;
    logic [LAT-1:0]        r_vld;
    logic                  w_cross;
    logic [XD-1:0]         r_xd;
    logic [COORD_BITS-1:0] w_px [4];
    logic [COORD_BITS-1:0] w_py [4];
    logic [COORD_BITS-1:0] w_ax [4];
    logic [COORD_BITS-1:0] w_ay [4];
    logic [COORD_BITS-1:0] w_bx [4];
    logic [COORD_BITS-1:0] w_by [4];
    logic [NW-1:0]         w_num [4];
    logic [SQ_W-1:0]       w_den [4];
    logic [QW-1:0]         w_quo [4];
    logic [SW-1:0]         w_root [4];
    logic [DIST_BITS-1:0]  w_dist [4];
    logic [DIST_BITS-1:0]  r_lo01, r_hi01, r_lo23, r_hi23;
    logic                  r_x1;
    t_seg_dist             r_res;

    assign busy = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    assign o_valid = r_vld[LAT-1];

    spd_cross u_cross (
        .i_clk      (i_clk),
        .i_item     (i_item),
        .o_crossing (w_cross)
    );

    always_ff @(posedge i_clk) begin
        r_xd <= {r_xd[XD-2:0], w_cross};
    end

    assign w_px[0] = i_item.seg1_start_x;
    assign w_py[0] = i_item.seg1_start_y;
    assign w_px[1] = i_item.seg1_end_x;
    assign w_py[1] = i_item.seg1_end_y;
    assign w_px[2] = i_item.seg2_start_x;
    assign w_py[2] = i_item.seg2_start_y;
    assign w_px[3] = i_item.seg2_end_x;
    assign w_py[3] = i_item.seg2_end_y;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        if (i < 2) begin : g_on2
            assign w_ax[i] = i_item.seg2_start_x;
            assign w_ay[i] = i_item.seg2_start_y;
            assign w_bx[i] = i_item.seg2_end_x;
            assign w_by[i] = i_item.seg2_end_y;
        end else begin : g_on1
            assign w_ax[i] = i_item.seg1_start_x;
            assign w_ay[i] = i_item.seg1_start_y;
            assign w_bx[i] = i_item.seg1_end_x;
            assign w_by[i] = i_item.seg1_end_y;
        end

        spd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_px  (w_px[i]),
            .i_py  (w_py[i]),
            .i_ax  (w_ax[i]),
            .i_ay  (w_ay[i]),
            .i_bx  (w_bx[i]),
            .i_by  (w_by[i]),
            .o_num (w_num[i]),
            .o_den (w_den[i])
        );

        spd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_num (w_num[i]),
            .i_den (w_den[i]),
            .o_quo (w_quo[i])
        );

        spd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
            .i_clk  (i_clk),
            .i_val  (w_quo[i]),
            .o_root (w_root[i])
        );

        if (SW > DIST_BITS) begin : g_sat
            assign w_dist[i] = (|w_root[i][SW-1:DIST_BITS]) ? DIST_MAX
                                                           : w_root[i][DIST_BITS-1:0];
        end else begin : g_ext
            assign w_dist[i] = DIST_BITS'(w_root[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo01 <= (w_dist[1] < w_dist[0]) ? w_dist[1] : w_dist[0];
        r_hi01 <= (w_dist[1] > w_dist[0]) ? w_dist[1] : w_dist[0];
        r_lo23 <= (w_dist[3] < w_dist[2]) ? w_dist[3] : w_dist[2];
        r_hi23 <= (w_dist[3] > w_dist[2]) ? w_dist[3] : w_dist[2];
        r_x1 <= r_xd[XD-1];

        r_res.crossing <= r_x1;
        r_res.nearest_distance <= r_x1 ? '0 : ((r_lo23 < r_lo01) ? r_lo23 : r_lo01);
        r_res.farthest_distance <= r_x1 ? '0 : ((r_hi23 > r_hi01) ? r_hi23 : r_hi01);
    end

    assign o_result = r_res;

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, LAT))
        else $error("result word without a matching start");

    a_cross_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.crossing) |->
            (o_result.nearest_distance == '0 && o_result.farthest_distance == '0))
        else $error("crossing word carries a distance");

    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.nearest_distance <= o_result.farthest_distance))
        else $error("nearest distance above farthest distance");

endmodule

`default_nettype wire

// File: rtl/spd_cross.sv
// Four-stage intersection test of two segments with exact cross products.
// Depends on spd_pkg.
`default_nettype none

module spd_cross (
    input  wire logic               i_clk,
    input  wire spd_pkg::t_seg_pair i_item,
    output logic                    o_crossing
);
    import spd_pkg::*;

    logic signed [DLT_W-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_e1, r_e2;
    logic signed [PRD_W-1:0] r_p21, r_p12, r_q11, r_q12, r_q21, r_q22;
    logic signed [SUM_W-1:0] r_delta, r_ns, r_nt;
    logic                    w_s_ok, w_t_ok;
    logic                    r_cross;

    always_ff @(posedge i_clk) begin
        r_dx1 <= $signed({1'b0, i_item.seg1_end_x}) - $signed({1'b0, i_item.seg1_start_x});
        r_dy1 <= $signed({1'b0, i_item.seg1_end_y}) - $signed({1'b0, i_item.seg1_start_y});
        r_dx2 <= $signed({1'b0, i_item.seg2_end_x}) - $signed({1'b0, i_item.seg2_start_x});
        r_dy2 <= $signed({1'b0, i_item.seg2_end_y}) - $signed({1'b0, i_item.seg2_start_y});
        r_e1  <= $signed({1'b0, i_item.seg2_start_y}) - $signed({1'b0, i_item.seg1_start_y});
        r_e2  <= $signed({1'b0, i_item.seg1_start_x}) - $signed({1'b0, i_item.seg2_start_x});
        r_p21 <= r_dx2 * r_dy1;
        r_p12 <= r_dy2 * r_dx1;
        r_q11 <= r_dx1 * r_e1;
        r_q12 <= r_dy1 * r_e2;
        r_q21 <= r_dx2 * r_e1;
        r_q22 <= r_dy2 * r_e2;
        r_delta <= SUM_W'(r_p21) - SUM_W'(r_p12);
        r_ns    <= SUM_W'(r_q11) + SUM_W'(r_q12);
        r_nt    <= SUM_W'(r_q21) + SUM_W'(r_q22);
        r_cross <= (r_delta != '0) && w_s_ok && w_t_ok;
    end

    always_comb begin
        if (!r_delta[SUM_W-1]) begin
            w_s_ok = !r_ns[SUM_W-1] && (r_ns <= r_delta);
            w_t_ok = !r_nt[SUM_W-1] && (r_nt <= r_delta);
        end else begin
            w_s_ok = (r_ns <= $signed(SUM_W'(0))) && (r_ns >= r_delta);
            w_t_ok = (r_nt <= $signed(SUM_W'(0))) && (r_nt >= r_delta);
        end
    end

    assign o_crossing = r_cross;

endmodule

`default_nettype wire

// File: rtl/spd_lane.sv
// Five-stage front end for one point-to-segment distance: it yields the squared distance,
// scaled by 2**(2*FRAC_BITS), as a numerator and denominator pair. Depends on spd_pkg.
`default_nettype none

module spd_lane #(
    parameter int FRAC_BITS = 4,
    localparam int NW = 2 * (spd_pkg::SQ_W + FRAC_BITS)
) (
    input  wire logic                           i_clk,
    input  wire logic [spd_pkg::COORD_BITS-1:0] i_px,
    input  wire logic [spd_pkg::COORD_BITS-1:0] i_py,
    input  wire logic [spd_pkg::COORD_BITS-1:0] i_ax,
    input  wire logic [spd_pkg::COORD_BITS-1:0] i_ay,
    input  wire logic [spd_pkg::COORD_BITS-1:0] i_bx,
    input  wire logic [spd_pkg::COORD_BITS-1:0] i_by,
    output logic      [NW-1:0]                  o_num,
    output logic      [spd_pkg::SQ_W-1:0]       o_den
);
    import spd_pkg::*;

    localparam int CW_W = SQ_W + FRAC_BITS;
    localparam int QW = SQ_W + 2 * FRAC_BITS;

    logic signed [DLT_W-1:0] r_dx, r_dy, r_wx, r_wy, r_vx, r_vy;
    logic signed [PRD_W-1:0] r_wdx, r_wdy, r_dxx, r_dyy, r_wxdy, r_wydx;
    logic signed [PRD_W-1:0] r_wxx, r_wyy, r_vxx, r_vyy;
    logic signed [SUM_W-1:0] r_tn, r_cr, w_cr_abs;
    logic        [SQ_W-1:0]  r_den, r_sqw, r_sqv;
    logic                    w_neg, w_gt, w_deg;
    logic                    r_perp;
    logic        [SQ_W-1:0]  r_abs, r_sq, r_den4;
    logic        [CW_W-1:0]  w_c;
    logic        [NW-1:0]    w_prod;
    logic        [QW-1:0]    w_sq;
    logic        [NW-1:0]    r_num;
    logic        [SQ_W-1:0]  r_den5;

    assign w_neg = r_tn[SUM_W-1];
    assign w_gt = r_tn > $signed(SUM_W'({1'b0, r_den}));
    assign w_deg = (r_den == '0);
    assign w_cr_abs = r_cr[SUM_W-1] ? -r_cr : r_cr;
    assign w_c = CW_W'(r_abs) << FRAC_BITS;
    assign w_prod = w_c * w_c;
    assign w_sq = QW'(r_sq) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        r_dx <= $signed({1'b0, i_bx}) - $signed({1'b0, i_ax});
        r_dy <= $signed({1'b0, i_by}) - $signed({1'b0, i_ay});
        r_wx <= $signed({1'b0, i_px}) - $signed({1'b0, i_ax});
        r_wy <= $signed({1'b0, i_py}) - $signed({1'b0, i_ay});
        r_vx <= $signed({1'b0, i_px}) - $signed({1'b0, i_bx});
        r_vy <= $signed({1'b0, i_py}) - $signed({1'b0, i_by});

        r_wdx  <= r_wx * r_dx;
        r_wdy  <= r_wy * r_dy;
        r_dxx  <= r_dx * r_dx;
        r_dyy  <= r_dy * r_dy;
        r_wxdy <= r_wx * r_dy;
        r_wydx <= r_wy * r_dx;
        r_wxx  <= r_wx * r_wx;
        r_wyy  <= r_wy * r_wy;
        r_vxx  <= r_vx * r_vx;
        r_vyy  <= r_vy * r_vy;

        r_tn  <= SUM_W'(r_wdx) + SUM_W'(r_wdy);
        r_cr  <= SUM_W'(r_wxdy) - SUM_W'(r_wydx);
        r_den <= SQ_W'(SUM_W'(r_dxx) + SUM_W'(r_dyy));
        r_sqw <= SQ_W'(SUM_W'(r_wxx) + SUM_W'(r_wyy));
        r_sqv <= SQ_W'(SUM_W'(r_vxx) + SUM_W'(r_vyy));

        r_perp <= !w_deg && !w_neg && !w_gt;
        r_sq   <= (w_deg || w_neg) ? r_sqw : r_sqv;
        r_abs  <= SQ_W'(w_cr_abs);
        r_den4 <= r_den;

        r_num  <= r_perp ? w_prod : NW'(w_sq);
        r_den5 <= r_perp ? r_den4 : SQ_W'(1);
    end

    assign o_num = r_num;
    assign o_den = r_den5;

endmodule

`default_nettype wire

// File: rtl/spd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on spd_pkg.
`default_nettype none

module spd_div #(
    parameter int FRAC_BITS = 4,
    localparam int DW = spd_pkg::SQ_W,
    localparam int QW = DW + 2 * FRAC_BITS,
    localparam int NW = DW + QW
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_z   [QW];
    logic [DW-1:0] r_d   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] s_rem, s_d;
        logic [QW-1:0] s_z;
        logic [DW:0]   s_t, s_diff;
        logic          s_ge;

        if (k == 0) begin : g_first
            assign s_rem = i_num[NW-1:QW];
            assign s_z = i_num[QW-1:0];
            assign s_d = i_den;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_z = r_z[k-1];
            assign s_d = r_d[k-1];
        end

        assign s_t = {s_rem, s_z[QW-1]};
        assign s_ge = s_t >= {1'b0, s_d};
        assign s_diff = s_t - {1'b0, s_d};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= s_ge ? s_diff[DW-1:0] : s_t[DW-1:0];
            r_z[k] <= {s_z[QW-2:0], s_ge};
            r_d[k] <= s_d;
        end
    end

    assign o_quo = r_z[QW-1];

endmodule

`default_nettype wire

// File: rtl/spd_sqrt.sv
// Pipelined floor square root, one root bit per register stage.
// Depends on spd_pkg.
`default_nettype none

module spd_sqrt #(
    parameter int FRAC_BITS = 4,
    localparam int QW = spd_pkg::SQ_W + 2 * FRAC_BITS,
    localparam int SW = (QW + 1) / 2
) (
    input  wire logic          i_clk,
    input  wire logic [QW-1:0] i_val,
    output logic      [SW-1:0] o_root
);
    localparam int XW = 2 * SW;

    logic [SW:0]   r_rem  [SW];
    logic [SW-1:0] r_root [SW];
    logic [XW-1:0] r_x    [SW];

    for (genvar k = 0; k < SW; k++) begin : g_step
        logic [SW:0]   s_rem;
        logic [SW-1:0] s_root;
        logic [XW-1:0] s_x;
        logic [SW+2:0] s_rr, s_trial, s_diff;
        logic          s_ge;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_root = '0;
            assign s_x = XW'(i_val);
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_x = r_x[k-1];
        end

        assign s_rr = {s_rem, s_x[XW-1:XW-2]};
        assign s_trial = {1'b0, s_root, 2'b01};
        assign s_ge = s_rr >= s_trial;
        assign s_diff = s_rr - s_trial;

        always_ff @(posedge i_clk) begin
            r_rem[k] <= s_ge ? s_diff[SW:0] : s_rr[SW:0];
            r_root[k] <= {s_root[SW-2:0], s_ge};
            r_x[k] <= s_x << 2;
        end
    end

    assign o_root = r_root[SW-1];

endmodule

`default_nettype wire

// File: tb/spd_checker.sv
// Checker for the segment pair distance block: watches the input and result channels,
// predicts each result word from the accepted segment pair and compares field by field.
// Depends on spd_pkg; instantiated beside the block by segment_pair_distance_tb.
module spd_checker #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire spd_pkg::t_seg_pair i_item,
    input  wire logic               i_valid,
    input  wire spd_pkg::t_seg_dist i_result,
    output int                      o_errors,
    output int                      o_pending
);
    import spd_pkg::*;

    t_seg_dist expected_dists[$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span_fixed(longint wx, longint wy);
        longint unsigned sq;
        sq = longint'(wx * wx + wy * wy);
        return root_floor(sq << (2 * FRAC_BITS));
    endfunction

    function automatic longint unsigned point_to_seg(longint px, longint py, longint ax,
                                                     longint ay, longint bx, longint by);
        longint dx, dy, wx, wy, proj, len2, cr;
        longint unsigned c;
        dx = bx - ax;
        dy = by - ay;
        wx = px - ax;
        wy = py - ay;
        if (dx == 0 && dy == 0) return span_fixed(wx, wy);
        proj = wx * dx + wy * dy;
        len2 = dx * dx + dy * dy;
        if (proj < 0) return span_fixed(wx, wy);
        if (proj > len2) return span_fixed(px - bx, py - by);
        cr = wx * dy - wy * dx;
        c = (cr < 0 ? -cr : cr) << FRAC_BITS;
        return root_floor((c * c) / longint'(len2));
    endfunction

    function automatic bit in_unit(longint num, longint den);
        if (den > 0) return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic t_seg_dist predict_dist(t_seg_pair p);
        t_seg_dist r;
        longint ax, ay, bx, by, cx, cy, ex, ey;
        longint dx1, dy1, dx2, dy2, delta, ns, nt;
        longint unsigned d[4];
        longint unsigned lo, hi;
        ax = p.seg1_start_x; ay = p.seg1_start_y;
        bx = p.seg1_end_x;   by = p.seg1_end_y;
        cx = p.seg2_start_x; cy = p.seg2_start_y;
        ex = p.seg2_end_x;   ey = p.seg2_end_y;
        dx1 = bx - ax; dy1 = by - ay;
        dx2 = ex - cx; dy2 = ey - cy;
        delta = dx2 * dy1 - dy2 * dx1;
        ns = dx1 * (cy - ay) + dy1 * (ax - cx);
        nt = -(dx2 * (ay - cy) + dy2 * (cx - ax));
        if (delta != 0 && in_unit(ns, delta) && in_unit(nt, delta)) begin
            r.crossing = 1'b1;
            r.nearest_distance = '0;
            r.farthest_distance = '0;
            return r;
        end
        d[0] = point_to_seg(ax, ay, cx, cy, ex, ey);
        d[1] = point_to_seg(bx, by, cx, cy, ex, ey);
        d[2] = point_to_seg(cx, cy, ax, ay, bx, by);
        d[3] = point_to_seg(ex, ey, ax, ay, bx, by);
        lo = d[0];
        hi = d[0];
        for (int i = 1; i < 4; i++) begin
            if (d[i] < lo) lo = d[i];
            if (d[i] > hi) hi = d[i];
        end
        r.crossing = 1'b0;
        r.nearest_distance = lo > DIST_MAX ? DIST_MAX : lo[DIST_BITS-1:0];
        r.farthest_distance = hi > DIST_MAX ? DIST_MAX : hi[DIST_BITS-1:0];
        return r;
    endfunction

    assign o_pending = expected_dists.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_seg_dist want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                expected_dists.insert(expected_dists.size(), predict_dist(i_item));
            end
            if (i_valid) begin
                if (expected_dists.size() == 0) begin
                    $display("%0t: result word with none expected: %p", $time, i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_dists.pop_front();
                    if (want.crossing !== i_result.crossing ||
                        want.nearest_distance !== i_result.nearest_distance ||
                        want.farthest_distance !== i_result.farthest_distance) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, i_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/segment_pair_distance_tb.sv
// Testbench top for segment_pair_distance: drives directed and random segment pairs with
// random gaps, and reports the verdict from spd_checker. Depends on spd_pkg and the RTL.
module segment_pair_distance_tb;
    import spd_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int STALL_LIMIT = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_seg_pair i_item = '0;
    logic      o_valid;
    t_seg_dist o_result;
    int        errors;
    int        pending;
    int        idle_cycles = 0;
    int        gap_style = 0;

    always #1 i_clk = ~i_clk;

    segment_pair_distance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    spd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_item(i_item), .i_valid(o_valid), .i_result(o_result),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_seg_pair pair_of(int ax, int ay, int bx, int by,
                                          int cx, int cy, int ex, int ey);
        t_seg_pair p;
        p.seg1_start_x = COORD_BITS'(ax);
        p.seg1_start_y = COORD_BITS'(ay);
        p.seg1_end_x = COORD_BITS'(bx);
        p.seg1_end_y = COORD_BITS'(by);
        p.seg2_start_x = COORD_BITS'(cx);
        p.seg2_start_y = COORD_BITS'(cy);
        p.seg2_end_x = COORD_BITS'(ex);
        p.seg2_end_y = COORD_BITS'(ey);
        return p;
    endfunction

    function automatic int near_coord(int center, int spread);
        int v;
        v = center + $urandom_range(2 * spread) - spread;
        return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
    endfunction

    function automatic t_seg_pair random_pair();
        t_seg_pair p;
        int kind, cx, cy, sp, ax, ay, dx, dy, k;
        kind = $urandom_range(99);
        cx = $urandom_range(COORD_MAX);
        cy = $urandom_range(COORD_MAX);
        sp = $urandom_range(3) == 0 ? 2000 : (1 << $urandom_range(8));
        if (kind < 30) begin
            p = t_seg_pair'({$urandom, $urandom, $urandom});
        end else if (kind < 70) begin
            p = pair_of(near_coord(cx, sp), near_coord(cy, sp), near_coord(cx, sp),
                        near_coord(cy, sp), near_coord(cx, sp), near_coord(cy, sp),
                        near_coord(cx, sp), near_coord(cy, sp));
        end else if (kind < 85) begin
            // Mostly parallel or collinear pairs: a moved second start can break the shared direction.
            ax = near_coord(cx, sp); ay = near_coord(cy, sp);
            dx = $urandom_range(16) - 8; dy = $urandom_range(16) - 8;
            k = $urandom_range(1) ? 0 : $urandom_range(20) - 10;
            p = pair_of(ax, ay, near_coord(ax + dx, 0), near_coord(ay + dy, 0),
                        near_coord(ax + k, 0), near_coord(ay + 3 * k, 0),
                        near_coord(ax + k + 2 * dx, 0), near_coord(ay + 3 * k + 2 * dy, 0));
            if ($urandom_range(1)) begin
                p.seg2_start_x = COORD_BITS'(near_coord(ax + 3 * dx, 0));
                p.seg2_start_y = COORD_BITS'(near_coord(ay + 3 * dy, 0));
            end
        end else begin
            // Degenerate segments and shared endpoints.
            p = pair_of(near_coord(cx, sp), near_coord(cy, sp), near_coord(cx, sp),
                        near_coord(cy, sp), near_coord(cx, sp), near_coord(cy, sp),
                        near_coord(cx, sp), near_coord(cy, sp));
            case ($urandom_range(2))
                0: begin
                    p.seg1_end_x = p.seg1_start_x; p.seg1_end_y = p.seg1_start_y;
                end
                1: begin
                    p.seg2_end_x = p.seg2_start_x; p.seg2_end_y = p.seg2_start_y;
                end
                default: begin
                    p.seg2_start_x = p.seg1_end_x; p.seg2_start_y = p.seg1_end_y;
                end
            endcase
        end
        return p;
    endfunction

    task automatic send_pair(t_seg_pair p);
        int gap;
        bit was_busy;
        gap = 0;
        if (gap_style != 0) gap = $urandom_range(9) < 6 ? 0 :
                                  ($urandom_range(19) == 0 ? $urandom_range(60)
                                                          : $urandom_range(3));
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = p;
        do begin
            was_busy = busy;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (was_busy);
    endtask

    initial begin
        t_seg_pair directed[$];
        directed = {
            pair_of(0, 0, 0, 0, 0, 0, 0, 0),
            pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
            pair_of(0, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
            pair_of(0, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0),
            pair_of(0, 0, 0, 0, COORD_MAX, 0, 0, COORD_MAX),
            pair_of(0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, 0),
            pair_of(0, 0, 100, 0, 50, 0, 200, 0),
            pair_of(0, 0, 100, 0, 200, 0, 300, 0),
            pair_of(0, 0, 100, 100, 10, 0, 110, 100),
            pair_of(0, 0, 100, 0, 100, 0, 100, 50),
            pair_of(0, 0, 100, 0, 50, 0, 50, 80),
            pair_of(0, 0, 100, 0, 50, 1, 50, 80),
            pair_of(10, 10, 20, 10, 0, 5, 5, 30),
            pair_of(10, 10, 20, 10, 25, 5, 40, 30),
            pair_of(10, 10, 20, 10, 15, 13, 15, 13),
            pair_of(0, 0, COORD_MAX, 1, 0, COORD_MAX, 1, 0),
            pair_of(0, 0, 1, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1),
            pair_of(COORD_MAX, 0, 0, COORD_MAX, 0, 0, 1, 1),
            pair_of(3, 7, 3, 7, 3, 7, 9, 2),
            pair_of(2730, 1365, 1365, 2730, 2730, 2730, 1365, 1365)
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_pair(directed[i]);
        for (int n = 0; n < 1650; n++) begin
            if (n % 100 == 0) gap_style = $urandom_range(2);
            if (n == 800) begin
                start = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            send_pair(random_pair());
        end
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
